>>> hw/rtl/postfix_stack_evaluator_assert.svh
// ----------------------------------------------------------------------------
// Postfix stack evaluator assertion macros
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_STACK_EVALUATOR_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_ASSERT_SVH

// Check cons in the same cycle as ante.
`define PSE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pse: same-cycle check failed");

// Check cons in the cycle after ante.
`define PSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pse: next-cycle check failed");

`endif

>>> hw/rtl/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types, codes and constants of the postfix stack evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pse_pkg;

    localparam int unsigned DATA_W          = 32;
    localparam int unsigned DEF_STACK_DEPTH = 64;

    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_DIVZERO   = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    typedef struct packed {
        logic [2:0]               opcode;
        logic signed [DATA_W-1:0] number_value;
        logic                     last_token;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [2:0]               status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_READ_A,
        S_EXEC,
        S_DIV_WAIT,
        S_WRITE,
        S_END,
        S_READ_TOP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic       ld_tok;
        logic       rd_en;
        logic       rd_second;
        logic       cap_b;
        logic       exec_alu;
        logic       div_start;
        logic       ld_quot;
        logic       push_num;
        logic       push_res;
        logic       pop2;
        logic       err_set;
        logic [2:0] err_code;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       last;
        logic       full;
        logic       lt2;
        logic       empty;
        logic       err_none;
        logic       b_zero;
        logic       div_done;
        logic       out_free;
    } t_stat;

endpackage

`default_nettype wire

>>> hw/rtl/pse_div.sv
// ----------------------------------------------------------------------------
// pse_div
// Signed truncating 32-bit divider, radix-2 restoring, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pse_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [pse_pkg::DATA_W-1:0] i_dividend,
    input  wire logic [pse_pkg::DATA_W-1:0] i_divisor,
    output logic      [pse_pkg::DATA_W-1:0] o_quotient,
    output logic                            o_done
);
    import pse_pkg::*;

    localparam int unsigned STEP_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dvs;
    logic              r_neg;
    logic [DATA_W:0]   w_shift;
    logic [DATA_W:0]   w_diff;
    logic              w_last_step;

    assign w_shift     = {r_rem, r_quo[DATA_W-1]};
    assign w_diff      = w_shift - {1'b0, r_dvs};
    assign w_last_step = (r_step == STEP_W'(DATA_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && w_last_step;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (w_last_step) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[DATA_W-1] ? (DATA_W'(0) - i_dividend) : i_dividend;
            r_dvs <= i_divisor[DATA_W-1] ? (DATA_W'(0) - i_divisor) : i_divisor;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_busy) begin
            r_rem <= w_diff[DATA_W] ? w_shift[DATA_W-1:0] : w_diff[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], ~w_diff[DATA_W]};
        end
    end

    assign o_quotient = r_neg ? (DATA_W'(0) - r_quo) : r_quo;
    assign o_done     = r_done;

endmodule

`default_nettype wire

>>> hw/rtl/pse_datapath.sv
// ----------------------------------------------------------------------------
// pse_datapath
// Operand stack memory, stack count, first-error register, ALU, divider
// and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "postfix_stack_evaluator_assert.svh"

module pse_datapath #(
    parameter int unsigned STACK_DEPTH = pse_pkg::DEF_STACK_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire pse_pkg::t_in_item  i_in_data,
    output pse_pkg::t_out_item      o_out_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    input  wire pse_pkg::t_cmd      i_cmd,
    output pse_pkg::t_stat          o_stat
);
    import pse_pkg::*;

    localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int unsigned ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [DATA_W-1:0] r_mem [STACK_DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic [DATA_W-1:0] r_b;
    logic [DATA_W-1:0] r_res;
    logic [CNT_W-1:0]  r_count;
    logic [2:0]        r_err;
    t_in_item          r_tok;
    t_out_item         r_out;
    logic              r_out_valid;

    logic [CNT_W-1:0]  w_cnt_m1;
    logic [CNT_W-1:0]  w_cnt_m2;
    logic [ADDR_W-1:0] w_ra;
    logic [ADDR_W-1:0] w_wa;
    logic [DATA_W-1:0] w_wd;
    logic              w_we;
    logic [DATA_W-1:0] w_alu;
    logic [DATA_W-1:0] w_quot;
    logic              w_div_done;
    logic              w_out_free;

    assign w_cnt_m1   = r_count - CNT_W'(1);
    assign w_cnt_m2   = r_count - CNT_W'(2);
    assign w_ra       = i_cmd.rd_second ? w_cnt_m2[ADDR_W-1:0] : w_cnt_m1[ADDR_W-1:0];
    assign w_we       = i_cmd.push_num || i_cmd.push_res;
    assign w_wa       = i_cmd.push_res ? w_cnt_m2[ADDR_W-1:0] : r_count[ADDR_W-1:0];
    assign w_wd       = i_cmd.push_res ? r_res : r_tok.number_value;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[w_ra];
        end
    end

    always_comb begin
        case (r_tok.opcode)
            OP_ADD:  w_alu = r_rd_data + r_b;
            OP_SUB:  w_alu = r_rd_data - r_b;
            OP_MUL:  w_alu = r_rd_data * r_b;
            default: w_alu = '0;
        endcase
    end

    pse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_rd_data),
        .i_divisor  (r_b),
        .o_quotient (w_quot),
        .o_done     (w_div_done)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_tok) begin
            r_tok <= i_in_data;
        end
        if (i_cmd.cap_b) begin
            r_b <= r_rd_data;
        end
        if (i_cmd.exec_alu) begin
            r_res <= w_alu;
        end else if (i_cmd.ld_quot) begin
            r_res <= w_quot;
        end
        if (i_cmd.out_load) begin
            if (r_err != ST_OK) begin
                r_out.result_value <= '0;
                r_out.status       <= r_err;
            end else if (r_count == '0) begin
                r_out.result_value <= '0;
                r_out.status       <= ST_EMPTY;
            end else begin
                r_out.result_value <= r_rd_data;
                r_out.status       <= ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.out_load) begin
                r_count     <= '0;
                r_err       <= ST_OK;
                r_out_valid <= 1'b1;
            end else begin
                if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
                if (i_cmd.err_set && (r_err == ST_OK)) begin
                    r_err <= i_cmd.err_code;
                end
                if (i_cmd.push_num) begin
                    r_count <= r_count + CNT_W'(1);
                end else if (i_cmd.push_res) begin
                    r_count <= w_cnt_m1;
                end else if (i_cmd.pop2) begin
                    r_count <= w_cnt_m2;
                end
            end
        end
    end

    always_comb begin
        o_stat.op       = r_tok.opcode;
        o_stat.last     = r_tok.last_token;
        o_stat.full     = (r_count == CNT_W'(STACK_DEPTH));
        o_stat.lt2      = (r_count < CNT_W'(2));
        o_stat.empty    = (r_count == '0);
        o_stat.err_none = (r_err == ST_OK);
        o_stat.b_zero   = (r_b == '0);
        o_stat.div_done = w_div_done;
        o_stat.out_free = w_out_free;
    end

    assign o_out_data  = r_out;
    assign o_out_valid = r_out_valid;

    `PSE_ASSERT_NOW(a_count_range, 1'b1, r_count <= CNT_W'(STACK_DEPTH))
    `PSE_ASSERT_NOW(a_pop_needs_two, i_cmd.push_res || i_cmd.pop2, r_count >= CNT_W'(2))
    `PSE_ASSERT_NEXT(a_result_clears, i_cmd.out_load, r_count == '0 && r_err == ST_OK && r_out_valid)

endmodule

`default_nettype wire

>>> hw/rtl/pse_ctrl.sv
// ----------------------------------------------------------------------------
// pse_ctrl
// Token sequencer: decodes each token and steps the datapath through stack
// reads, arithmetic, writeback and result delivery.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "postfix_stack_evaluator_assert.svh"

module pse_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output pse_pkg::t_cmd       o_cmd,
    input  wire pse_pkg::t_stat i_stat
);
    import pse_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if ((i_stat.op == OP_PUSH) || i_stat.lt2) begin
                    n_state = S_END;
                end else begin
                    n_state = S_READ_A;
                end
            end
            S_READ_A: n_state = S_EXEC;
            S_EXEC: begin
                case (i_stat.op)
                    OP_ADD, OP_SUB, OP_MUL: n_state = S_WRITE;
                    OP_DIV:  n_state = i_stat.b_zero ? S_WRITE : S_DIV_WAIT;
                    default: n_state = S_END;
                endcase
            end
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: n_state = S_END;
            S_END: begin
                if (!i_stat.last) begin
                    n_state = S_IDLE;
                end else if (!i_stat.err_none || i_stat.empty) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_READ_TOP;
                end
            end
            S_READ_TOP: n_state = S_OUT;
            S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.ld_tok = i_in_valid;
            end
            S_DECODE: begin
                if (i_stat.op == OP_PUSH) begin
                    if (i_stat.full) begin
                        o_cmd.err_set  = 1'b1;
                        o_cmd.err_code = ST_OVERFLOW;
                    end else begin
                        o_cmd.push_num = 1'b1;
                    end
                end else if (i_stat.lt2) begin
                    o_cmd.err_set  = 1'b1;
                    o_cmd.err_code = ST_UNDERFLOW;
                end else begin
                    o_cmd.rd_en = 1'b1;
                end
            end
            S_READ_A: begin
                o_cmd.cap_b     = 1'b1;
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_second = 1'b1;
            end
            S_EXEC: begin
                case (i_stat.op)
                    OP_ADD, OP_SUB, OP_MUL: o_cmd.exec_alu = 1'b1;
                    OP_DIV: begin
                        if (i_stat.b_zero) begin
                            o_cmd.exec_alu = 1'b1;
                            o_cmd.err_set  = 1'b1;
                            o_cmd.err_code = ST_DIVZERO;
                        end else begin
                            o_cmd.div_start = 1'b1;
                        end
                    end
                    default: o_cmd.pop2 = 1'b1;
                endcase
            end
            S_DIV_WAIT: o_cmd.ld_quot = i_stat.div_done;
            S_WRITE:    o_cmd.push_res = 1'b1;
            S_END: begin
                if (i_stat.last && i_stat.err_none && !i_stat.empty) begin
                    o_cmd.rd_en = 1'b1;
                end
            end
            S_READ_TOP: o_cmd = '0;
            S_OUT:      o_cmd.out_load = i_stat.out_free;
            default:    o_cmd = '0;
        endcase
    end

    `PSE_ASSERT_NOW(a_load_needs_slot, o_cmd.out_load, i_stat.out_free)
    `PSE_ASSERT_NOW(a_push_not_full, o_cmd.push_num, !i_stat.full)
    `PSE_ASSERT_NOW(a_div_nonzero, o_cmd.div_start, !i_stat.b_zero && i_stat.op == OP_DIV)
    `PSE_ASSERT_NEXT(a_div_waits, r_state == S_DIV_WAIT && !i_stat.div_done, r_state == S_DIV_WAIT)

endmodule

`default_nettype wire

>>> hw/rtl/postfix_stack_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Postfix expression evaluator: one token per input transaction, one
// result transaction on each token marked last.
// ----------------------------------------------------------------------------
// Tokens are taken one at a time. A divide waits on the radix-2 divider,
// which resolves one quotient bit per cycle over 32 iterations. Each
// operator reads its two operands from the single read port of the stack
// memory on successive cycles. A token marked last places the result in
// the output register; the next token is accepted while that result waits.
// An error status returns result 0; the stack and the error clear after
// each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module postfix_stack_evaluator #(
    parameter int unsigned STACK_DEPTH = pse_pkg::DEF_STACK_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire pse_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output pse_pkg::t_out_item      o_out_data
);
    import pse_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    pse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    pse_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

endmodule

`default_nettype wire
